// ===== sv/chi_pkg.sv =====
// ----------------------------------------------------------------------------
// chi_pkg
// Shared types, constants and helpers for the cell hash intern block.
// ----------------------------------------------------------------------------
package chi_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int INDEX_W     = 10;
	localparam int COUNT_W     = 24;
	localparam int COORD_W     = 21;
	localparam int KEY_W       = 3 * COORD_W;

	localparam logic signed [32:0] COORD_BIAS = 33'sd1048576;
	localparam logic signed [32:0] COORD_MAX  = 33'sd2097151;

	localparam logic [63:0] HASH_ADD = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] HASH_M1  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] HASH_M2  = 64'h94d049bb133111eb;

	// Request kinds. The fourth code behaves as a lookup.
	localparam logic [1:0] MODE_INTERN = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	// Result status codes.
	localparam logic [2:0] STAT_FOUND    = 3'd0;
	localparam logic [2:0] STAT_INSERTED = 3'd1;
	localparam logic [2:0] STAT_MISS     = 3'd2;
	localparam logic [2:0] STAT_FULL     = 3'd3;
	localparam logic [2:0] STAT_CLEARED  = 3'd4;

	// One table entry as stored in the slot memory.
	typedef struct packed {
		logic               used;
		logic [KEY_W-1:0]   key;
		logic [INDEX_W-1:0] index;
		logic [COUNT_W-1:0] tally;
	} slot_t;

	localparam int SLOT_BITS = $bits(slot_t);

	// Bias a signed coordinate by 2^20 and clamp it into 21 bits.
	function automatic logic [COORD_W-1:0] biased_axis(input logic [31:0] raw);
		logic signed [32:0] v;
		v = $signed({raw[31], raw}) + COORD_BIAS;
		if (v < 0) begin
			return '0;
		end else if (v > COORD_MAX) begin
			return '1;
		end
		return v[COORD_W-1:0];
	endfunction

endpackage

// ===== sv/chi_ram.sv =====
// ----------------------------------------------------------------------------
// chi_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module chi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/chi_hash.sv =====
// ----------------------------------------------------------------------------
// chi_hash
// Iterative 64-bit mixing finalizer built around one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module chi_hash import chi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KEY_W-1:0]  key,
	output logic              done,
	output logic [SLOT_W-1:0] slot
);

	typedef enum logic [3:0] {
		H_IDLE = 4'b0001,
		H_MIX  = 4'b0010,
		H_MUL  = 4'b0100,
		H_FIN  = 4'b1000
	} hash_state_t;

	hash_state_t      hst_q;
	logic             round_q;
	logic [1:0]       cnt_q;
	logic             done_q;
	logic [63:0]      h_q;
	logic [63:0]      a_q;
	logic [63:0]      prod_q;
	logic [SLOT_W-1:0] slot_q;

	logic [63:0] mult_c;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] mix;
	logic [63:0] fin;

	// The low 64 bits of a product need aL*cL, aL*cH and aH*cL only.
	assign mult_c = round_q ? HASH_M2 : HASH_M1;
	assign mul_a  = (cnt_q == 2'd2) ? a_q[63:32] : a_q[31:0];
	assign mul_b  = (cnt_q == 2'd1) ? mult_c[63:32] : mult_c[31:0];
	assign mul_p  = 64'(mul_a) * 64'(mul_b);
	assign mix    = round_q ? (h_q ^ (h_q >> 27)) : (h_q ^ (h_q >> 30));
	assign fin    = h_q ^ (h_q >> 31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hst_q   <= H_IDLE;
			round_q <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (hst_q)
				H_IDLE: begin
					if (start) begin
						round_q <= 1'b0;
						hst_q   <= H_MIX;
					end
				end
				H_MIX: begin
					cnt_q <= '0;
					hst_q <= H_MUL;
				end
				H_MUL: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						if (round_q) begin
							hst_q <= H_FIN;
						end else begin
							round_q <= 1'b1;
							hst_q   <= H_MIX;
						end
					end
				end
				H_FIN: begin
					done_q <= 1'b1;
					hst_q  <= H_IDLE;
				end
				default: hst_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hst_q == H_IDLE && start) begin
			h_q <= {1'b0, key} + HASH_ADD;
		end
		if (hst_q == H_MIX) begin
			a_q <= mix;
		end
		if (hst_q == H_MUL) begin
			if (cnt_q != 2'd3) begin
				prod_q <= mul_p;
			end
			if (cnt_q == 2'd1) begin
				h_q <= prod_q;
			end else if (cnt_q != 2'd0) begin
				h_q[63:32] <= h_q[63:32] + prod_q[31:0];
			end
		end
		if (hst_q == H_FIN) begin
			slot_q <= fin[SLOT_W-1:0];
		end
	end

	assign done = done_q;
	assign slot = slot_q;

endmodule

// ===== sv/cell_hash_intern_core.sv =====
// ----------------------------------------------------------------------------
// cell_hash_intern_core
// Interns 3-D grid cell coordinates into dense first-seen indices.
// ----------------------------------------------------------------------------
// Each request beat carries a mode and three signed cell coordinates. An
// intern request looks the cell up in a 1024-slot open-addressed table, adds
// it under the next dense index if it is new, and bumps its saturating
// element count; a lookup only reports; a clear empties the table. Every
// request gives exactly one result beat. The block handles one request at a
// time: the hash runs on a single shared 32x32 multiplier (two 64-bit
// products of three partial products each), and every probe then goes
// through the registered read port of the slot memory (states ST_READ and
// ST_CHECK). A request makes up to 1024 probes when the table is nearly
// full. A clear, and the start after reset, walk the slot memory one entry
// a cycle while s_tready stays low. A finished result waits in the output
// register, so the next request is accepted while the previous result is
// not yet taken.
// ----------------------------------------------------------------------------
module cell_hash_intern_core import chi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	// Fields from bit 0: cell_x[31:0], cell_y[63:32], cell_z[95:64].
	input  logic [95:0] s_tdata,
	// Fields from bit 0: mode[1:0].
	input  logic [1:0]  s_tuser,

	output logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0: cell_index[9:0], cell_count[33:10], zero fill[39:34].
	output logic [39:0] m_tdata,
	// Fields from bit 0: status[2:0].
	output logic [2:0]  m_tuser
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_HASH  = 6'b000100,
		ST_READ  = 6'b001000,
		ST_CHECK = 6'b010000,
		ST_PUSH  = 6'b100000
	} state_t;

	state_t             state_q;
	logic [SLOT_W-1:0]  clr_addr_q;
	logic               clr_report_q;
	logic               intern_q;
	logic [KEY_W-1:0]   key_q;
	logic [SLOT_W-1:0]  probe_slot_q;
	logic [SLOT_W:0]    probe_cnt_q;
	logic [INDEX_W:0]   next_index_q;
	logic [2:0]         res_status_q;
	logic [INDEX_W-1:0] res_index_q;
	logic [COUNT_W-1:0] res_count_q;
	logic               out_valid_q;
	logic [2:0]         out_status_q;
	logic [INDEX_W-1:0] out_index_q;
	logic [COUNT_W-1:0] out_count_q;

	logic               accept;
	logic               hash_start;
	logic               hash_done;
	logic [SLOT_W-1:0]  hash_slot;
	logic [KEY_W-1:0]   req_key;

	logic                 ram_we;
	logic [SLOT_W-1:0]    ram_waddr;
	slot_t                ram_wdata;
	logic                 ram_re;
	logic [SLOT_BITS-1:0] ram_rdata;
	slot_t                rd;

	logic               hit;
	logic               empty;
	logic               last_probe;
	logic [COUNT_W-1:0] tally_new;
	logic               push_load;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Packed key: x in the high third, z in the low third.
	assign req_key = {biased_axis(s_tdata[31:0]), biased_axis(s_tdata[63:32]),
		biased_axis(s_tdata[95:64])};

	assign hash_start = accept && (s_tuser != MODE_CLEAR);

	chi_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (req_key),
		.done   (hash_done),
		.slot   (hash_slot)
	);

	// Probe decision on the slot just read.
	assign rd         = slot_t'(ram_rdata);
	assign empty      = !rd.used;
	assign hit        = rd.used && (rd.key == key_q);
	assign last_probe = (probe_cnt_q == (SLOT_W + 1)'(TABLE_DEPTH - 1));
	assign tally_new  = (intern_q && !(&rd.tally)) ? rd.tally + COUNT_W'(1) : rd.tally;

	assign ram_re = (state_q == ST_READ);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = probe_slot_q;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
		end else if (state_q == ST_CHECK && intern_q) begin
			if (empty) begin
				ram_we          = 1'b1;
				ram_wdata.used  = 1'b1;
				ram_wdata.key   = key_q;
				ram_wdata.index = next_index_q[INDEX_W-1:0];
				ram_wdata.tally = COUNT_W'(1);
			end else if (hit) begin
				ram_we          = 1'b1;
				ram_wdata       = rd;
				ram_wdata.tally = tally_new;
			end
		end
	end

	chi_ram #(
		.WIDTH (SLOT_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (probe_slot_q),
		.rdata (ram_rdata)
	);

	assign push_load = (state_q == ST_PUSH) && (!out_valid_q || m_tready);

	// Sequencer: the reset state is the clearing pass, with no result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_addr_q   <= '0;
			clr_report_q <= 1'b0;
			next_index_q <= '0;
			probe_cnt_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + SLOT_W'(1);
					if (clr_addr_q == SLOT_W'(TABLE_DEPTH - 1)) begin
						state_q <= clr_report_q ? ST_PUSH : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == MODE_CLEAR) begin
							clr_addr_q   <= '0;
							clr_report_q <= 1'b1;
							next_index_q <= '0;
							state_q      <= ST_CLEAR;
						end else begin
							state_q <= ST_HASH;
						end
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						probe_cnt_q <= '0;
						state_q     <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (empty || hit || last_probe) begin
						if (empty && intern_q) begin
							next_index_q <= next_index_q + (INDEX_W + 1)'(1);
						end
						state_q <= ST_PUSH;
					end else begin
						probe_cnt_q <= probe_cnt_q + (SLOT_W + 1)'(1);
						state_q     <= ST_READ;
					end
				end
				ST_PUSH: begin
					if (push_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request, probe and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= req_key;
			intern_q <= (s_tuser == MODE_INTERN);
		end
		if (state_q == ST_HASH && hash_done) begin
			probe_slot_q <= hash_slot;
		end
		if (state_q == ST_CLEAR) begin
			res_status_q <= STAT_CLEARED;
			res_index_q  <= '0;
			res_count_q  <= '0;
		end
		if (state_q == ST_CHECK) begin
			if (empty) begin
				res_status_q <= intern_q ? STAT_INSERTED : STAT_MISS;
				res_index_q  <= intern_q ? next_index_q[INDEX_W-1:0] : '0;
				res_count_q  <= intern_q ? COUNT_W'(1) : '0;
			end else if (hit) begin
				res_status_q <= STAT_FOUND;
				res_index_q  <= rd.index;
				res_count_q  <= tally_new;
			end else if (last_probe) begin
				res_status_q <= intern_q ? STAT_FULL : STAT_MISS;
				res_index_q  <= '0;
				res_count_q  <= '0;
			end else begin
				probe_slot_q <= probe_slot_q + SLOT_W'(1);
			end
		end
		if (push_load) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_count_q  <= res_count_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {6'b0, out_count_q, out_index_q};

	// The dense index never runs past the number of slots.
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_index_q <= (INDEX_W + 1)'(TABLE_DEPTH))
		else $error("next index beyond table depth");

	// A probe run never goes past one full lap of the table.
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		probe_cnt_q < (SLOT_W + 1)'(TABLE_DEPTH))
		else $error("probe count beyond table depth");

	// The slot memory is written only by the clearing pass or a probe decision.
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_CHECK))
		else $error("slot write outside clear or check");

	// After a request is taken the block stays busy until its result is staged.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("request taken while busy");

	// A hash result only arrives while the sequencer waits for it.
	a_hash_wait: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> (state_q == ST_HASH))
		else $error("hash done outside hash wait");

endmodule
